// File: design/ilsr_pkg.sv
// ----------------------------------------------------------------------------
// ilsr_pkg - shared types and codes for the indexed list
// item layouts for both channels, action and status codes
// ----------------------------------------------------------------------------
package ilsr_pkg;

  // action codes carried by an input item
  localparam logic [2:0] ACT_PUSH_BACK = 3'd0;
  localparam logic [2:0] ACT_READ      = 3'd1;
  localparam logic [2:0] ACT_POP_BACK  = 3'd2;
  localparam logic [2:0] ACT_REMOVE    = 3'd3;
  localparam logic [2:0] ACT_POP_HEAD  = 3'd4;

  // status codes carried by a result item
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  position;
    logic [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  count;
  } out_item_t;

endpackage

// File: design/indexed_list_with_shift_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_with_shift_remove - bounded ordered word list
// push back, read at index, pop back, remove at index and pop head over a
// single-port-write / single-port-read memory with a shift sequencer
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a rising edge where start is high and busy is low;
//   busy stays high until the result has been shown
//   each item gives exactly one result: out_valid is high for one cycle and
//   out_item holds status, the word read or popped and the entry count
//   after the item; the receiver cannot hold results off
// sequence
//   push back or any rejected item: idle, then done
//   read and pop back: idle, look, prime, done (one registered memory read)
//   remove at index p and pop head (p = 0): idle, look, prime, then one
//   shift step for each of the count_before - 1 - p entries behind p, then
//   done; the shift moves one entry per cycle through the one memory
//   read port and the one write port
// throughput
//   the next item can be taken in the cycle after out_valid; no new item
//   is taken while one is still in the sequence above
// reset
//   rst_n (synchronous, active low) empties the list and returns the
//   sequencer to idle; entry storage is not cleared, only entries below the
//   count are used, though ones past it may also be read
// ----------------------------------------------------------------------------
module indexed_list_with_shift_remove #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ilsr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ilsr_pkg::out_item_t out_item
);

  // address width and count width (count must hold CAPACITY itself)
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_PRIME = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [2:0]            action_r, action_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;

  // entry storage
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [AW-1:0]         mem_ra;

  logic                  accept;
  logic                  pos_bad;
  logic                  list_full;
  logic                  list_empty;

  assign accept     = start && (state_r == S_IDLE);
  assign pos_bad    = 32'(in_item.position) >= 32'(fill_r);
  assign list_full  = fill_r == CW'(CAPACITY);
  assign list_empty = fill_r == '0;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    action_nxt = action_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    mem_we     = 1'b0;
    mem_wa     = ptr_r;
    mem_wd     = rd_data_r;
    mem_ra     = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          action_nxt = in_item.action;
          status_nxt = ilsr_pkg::ST_OK;
          value_nxt  = '0;
          state_nxt  = S_DONE;
          case (in_item.action)
            ilsr_pkg::ACT_PUSH_BACK: begin
              // write straight into the free slot at the back
              if (list_full) begin
                status_nxt = ilsr_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = AW'(fill_r);
                mem_wd   = DATA_WIDTH'(in_item.item_value);
                fill_nxt = fill_r + CW'(1);
              end
            end
            ilsr_pkg::ACT_READ: begin
              if (pos_bad) begin
                status_nxt = ilsr_pkg::ST_RANGE;
              end else begin
                ptr_nxt   = AW'(in_item.position);
                state_nxt = S_LOOK;
              end
            end
            ilsr_pkg::ACT_POP_BACK: begin
              if (list_empty) begin
                status_nxt = ilsr_pkg::ST_RANGE;
              end else begin
                ptr_nxt   = AW'(fill_r - CW'(1));
                fill_nxt  = fill_r - CW'(1);
                state_nxt = S_LOOK;
              end
            end
            ilsr_pkg::ACT_REMOVE: begin
              if (pos_bad) begin
                status_nxt = ilsr_pkg::ST_RANGE;
              end else begin
                ptr_nxt   = AW'(in_item.position);
                fill_nxt  = fill_r - CW'(1);
                state_nxt = S_LOOK;
              end
            end
            ilsr_pkg::ACT_POP_HEAD: begin
              if (list_empty) begin
                status_nxt = ilsr_pkg::ST_RANGE;
              end else begin
                ptr_nxt   = '0;
                fill_nxt  = fill_r - CW'(1);
                state_nxt = S_LOOK;
              end
            end
            default: begin
              // unknown action: list untouched
              status_nxt = ilsr_pkg::ST_RANGE;
            end
          endcase
        end
      end
      S_LOOK: begin
        // fetch the target entry
        mem_ra    = ptr_r;
        state_nxt = S_PRIME;
      end
      S_PRIME: begin
        // target word is now in rd_data_r; start fetching the first source
        mem_ra = AW'(CW'(ptr_r) + CW'(1));
        if (action_r != ilsr_pkg::ACT_REMOVE) begin
          value_nxt = rd_data_r;
        end
        if (action_r == ilsr_pkg::ACT_REMOVE || action_r == ilsr_pkg::ACT_POP_HEAD) begin
          // fill_r already holds the count after removal
          state_nxt = (CW'(ptr_r) >= fill_r) ? S_DONE : S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        // move entry ptr+1 down to ptr, prefetch entry ptr+2
        mem_we = 1'b1;
        mem_wa = ptr_r;
        mem_wd = rd_data_r;
        mem_ra = AW'(CW'(ptr_r) + CW'(2));
        if ((CW'(ptr_r) + CW'(1)) >= fill_r) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // payload and pointer registers, no reset needed
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    action_r <= action_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign busy                = state_r != S_IDLE;
  assign out_valid           = state_r == S_DONE;
  assign out_item.status     = status_r;
  assign out_item.read_value = 32'(value_r);
  assign out_item.count      = 5'(fill_r);

  // checks
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("result not followed by idle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ilsr_pkg::ST_FULL) |-> list_full)
    else $error("full status with room left");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ilsr_pkg::ST_OK) |-> out_item.read_value == '0)
    else $error("rejected item returned a word");

endmodule

// File: dv/list_result_checker.sv
// ----------------------------------------------------------------------------
// list_result_checker - result checker for the indexed word list
// watches the command and result channels, keeps a shadow copy of the list,
// works out the result of every accepted item and compares it field by field
// ----------------------------------------------------------------------------
module list_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  ilsr_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  ilsr_pkg::out_item_t out_item,
  output int unsigned         fail_count,
  output int unsigned         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]         shadow_words [CAPACITY];
  int unsigned         shadow_len;
  ilsr_pkg::out_item_t awaited_results [$];
  int unsigned         errors;

  initial begin
    shadow_len    = 0;
    errors        = 0;
    fail_count    = 0;
    pending_count = 0;
  end

  // close the gap left by the entry at pos
  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_len; i++)
      shadow_words[i] = shadow_words[i + 1];
    shadow_len--;
  endfunction

  function automatic ilsr_pkg::out_item_t apply_list_request(ilsr_pkg::in_item_t req);
    ilsr_pkg::out_item_t res;
    int unsigned         pos;
    res        = '0;
    res.status = ilsr_pkg::ST_OK;
    pos        = req.position;
    case (req.action)
      ilsr_pkg::ACT_PUSH_BACK: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ilsr_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_len] = req.item_value;
          shadow_len++;
        end
      end
      ilsr_pkg::ACT_READ: begin
        if (pos >= shadow_len) res.status = ilsr_pkg::ST_RANGE;
        else res.read_value = shadow_words[pos];
      end
      ilsr_pkg::ACT_POP_BACK: begin
        if (shadow_len == 0) begin
          res.status = ilsr_pkg::ST_RANGE;
        end else begin
          shadow_len--;
          res.read_value = shadow_words[shadow_len];
        end
      end
      ilsr_pkg::ACT_REMOVE: begin
        if (pos >= shadow_len) res.status = ilsr_pkg::ST_RANGE;
        else drop_entry(pos);
      end
      ilsr_pkg::ACT_POP_HEAD: begin
        if (shadow_len == 0) begin
          res.status = ilsr_pkg::ST_RANGE;
        end else begin
          res.read_value = shadow_words[0];
          drop_entry(0);
        end
      end
      default: res.status = ilsr_pkg::ST_RANGE;
    endcase
    res.count = 5'(shadow_len);
    return res;
  endfunction

  task automatic flag_failure(string msg);
    errors++;
    if (errors <= 10) $display("%0t ns list check: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch_channels
    ilsr_pkg::out_item_t want;
    if (!rst_n) begin
      shadow_len = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          flag_failure($sformatf(
            "result with nothing outstanding: status %0d value %08h count %0d",
            out_item.status, out_item.read_value, out_item.count));
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status)
            flag_failure($sformatf("status expected %0d got %0d",
                                   want.status, out_item.status));
          if (out_item.read_value !== want.read_value)
            flag_failure($sformatf("read_value expected %08h got %08h",
                                   want.read_value, out_item.read_value));
          if (out_item.count !== want.count)
            flag_failure($sformatf("count expected %0d got %0d",
                                   want.count, out_item.count));
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_list_request(in_item));
    end
    pending_count <= awaited_results.size();
    fail_count    <= errors;
  end

endmodule

// File: dv/indexed_list_with_shift_remove_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_with_shift_remove_tb - testbench for the indexed word list
// drives a directed pass over empty, full and out-of-range cases, then bursts
// of random requests biased to fill, drain or churn the list; a checker beside
// the block predicts and compares every result
// ----------------------------------------------------------------------------
module indexed_list_with_shift_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // action codes the block does not know, kept in the stimulus on purpose
  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1720;
  localparam int unsigned BURST_LEN    = 40;
  localparam int unsigned IDLE_PCT     = 29;
  // cycles with nothing moving on either channel before the run is abandoned;
  // the slowest item is a pop head on a full list
  localparam int unsigned STALL_LIMIT  = 2000;
  // quiet time after the last result, well past the longest shift
  localparam int unsigned TAIL_CYCLES  = 32;

  typedef enum {FILL_HEAVY, DRAIN_HEAVY, MIXED, NOISE} traffic_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  ilsr_pkg::in_item_t  in_item;
  logic                out_valid;
  ilsr_pkg::out_item_t out_item;
  int unsigned         fail_count;
  int unsigned         pending_count;
  int unsigned         stall_cycles = 0;
  bit                  idling_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  indexed_list_with_shift_remove DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  list_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // watchdog: any accepted item or shown result restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic ilsr_pkg::in_item_t make_request(logic [2:0] act, logic [3:0] pos,
                                                      logic [31:0] word);
    ilsr_pkg::in_item_t req;
    req.action     = act;
    req.position   = pos;
    req.item_value = word;
    return req;
  endfunction

  // random request shaped by the current traffic mode
  function automatic ilsr_pkg::in_item_t random_request(traffic_mode_t mode);
    ilsr_pkg::in_item_t req;
    int unsigned        roll;
    int unsigned        t_push, t_read, t_popb, t_rem, t_poph;
    roll = $urandom_range(0, 99);
    // cumulative thresholds, the rest of the hundred goes to unknown actions
    case (mode)
      FILL_HEAVY:  begin t_push = 60; t_read = 80; t_popb = 85; t_rem = 93; t_poph = 98; end
      DRAIN_HEAVY: begin t_push = 15; t_read = 30; t_popb = 55; t_rem = 78; t_poph = 98; end
      default:     begin t_push = 35; t_read = 60; t_popb = 72; t_rem = 86; t_poph = 98; end
    endcase
    if (mode == NOISE)        req.action = 3'($urandom);
    else if (roll < t_push)   req.action = ilsr_pkg::ACT_PUSH_BACK;
    else if (roll < t_read)   req.action = ilsr_pkg::ACT_READ;
    else if (roll < t_popb)   req.action = ilsr_pkg::ACT_POP_BACK;
    else if (roll < t_rem)    req.action = ilsr_pkg::ACT_REMOVE;
    else if (roll < t_poph)   req.action = ilsr_pkg::ACT_POP_HEAD;
    else req.action = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
    // half the positions near the head where entries usually exist
    if ($urandom_range(0, 1) == 0) req.position = 4'($urandom_range(0, 3));
    else req.position = 4'($urandom);
    // mostly random words, with some all-zero, all-one and one-hot ones
    case ($urandom_range(0, 9))
      0:       req.item_value = '0;
      1:       req.item_value = '1;
      2:       req.item_value = 32'h1 << $urandom_range(0, 31);
      default: req.item_value = $urandom;
    endcase
    return req;
  endfunction

  // present one item, with random idle cycles ahead of it, and hold it until
  // the block takes it; start stays high into the next item when no idle follows
  task automatic send_item(ilsr_pkg::in_item_t req);
    while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    traffic_mode_t mode;
    logic [31:0]   word;
    int unsigned   pick;
    start     = 1'b0;
    in_item   = '0;
    rst_n     = 1'b0;
    idling_on = 1'b1;
    mode      = MIXED;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // everything that can go wrong on an empty list
    send_item(make_request(ilsr_pkg::ACT_POP_BACK, 4'd0, '0));
    send_item(make_request(ilsr_pkg::ACT_POP_HEAD, 4'd0, '0));
    send_item(make_request(ilsr_pkg::ACT_READ, 4'd3, '0));
    send_item(make_request(ilsr_pkg::ACT_REMOVE, 4'd0, '0));
    send_item(make_request(ACT_LAST_UNUSED - 3'd1, 4'hf, '1));

    // fill to capacity, extreme words first
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       word = '0;
        1:       word = '1;
        2:       word = 32'h8000_0000;
        3:       word = 32'h0000_0001;
        default: word = $urandom;
      endcase
      send_item(make_request(ilsr_pkg::ACT_PUSH_BACK, 4'($urandom), word));
    end

    // push onto a full list is dropped, then the top index is read, removed,
    // and read again past the end
    send_item(make_request(ilsr_pkg::ACT_PUSH_BACK, 4'd0, 32'hdead_beef));
    send_item(make_request(ilsr_pkg::ACT_READ, 4'hf, '0));
    send_item(make_request(ilsr_pkg::ACT_REMOVE, 4'hf, '0));
    send_item(make_request(ilsr_pkg::ACT_READ, 4'hf, '0));
    send_item(make_request(ilsr_pkg::ACT_POP_HEAD, 4'd0, '0));
    send_item(make_request(ilsr_pkg::ACT_POP_BACK, 4'd0, '0));
    wait_for_drain();

    // random bursts; a stretch in the middle runs with no idle cycles and two
    // pauses let the list settle with nothing in flight
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BURST_LEN == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)     mode = NOISE;
        else if (pick < 4) mode = FILL_HEAVY;
        else if (pick < 7) mode = DRAIN_HEAVY;
        else               mode = MIXED;
      end
      idling_on = !(n >= 700 && n < 1000);
      if (n == 400 || n == 1200) wait_for_drain();
      send_item(random_request(mode));
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
design/ilsr_pkg.sv
design/indexed_list_with_shift_remove.sv
dv/list_result_checker.sv
dv/indexed_list_with_shift_remove_tb.sv
